### rtl/ssa_pkg.sv
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared constants and types of the sensor sample aggregator.
// ----------------------------------------------------------------------------
`default_nettype none
package ssa_pkg;
   localparam int CHANNELS_DEF   = 4;
   localparam int COUNT_BITS_DEF = 16;
   localparam int SUM_BITS       = 48;
   localparam int DIVIDEND_BITS  = 49;
   localparam int MAX_RESULTS    = 4;
   // 0.11 in Q16.16
   localparam logic signed [32:0] TOL_Q = 33'sd7209;

   localparam logic [31:0] LOWER_RST   = 32'h8000_0000;
   localparam logic [31:0] UPPER_RST   = 32'h7FFF_FFFF;
   localparam logic [31:0] MARKER_RST  = 32'd65530675;
   localparam logic [31:0] SEND_RST    = 32'd600;
   localparam logic [31:0] INVAL_RST   = 32'd1800;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;
endpackage
`default_nettype wire

### rtl/sensor_sample_aggregator_core.sv
// ----------------------------------------------------------------------------
// sensor_sample_aggregator_core
// Per-channel sample store with running averages and checked readout.
// ----------------------------------------------------------------------------
// Usage:
//  req_* carries one item per transfer: a new sample (op 0) or a raw (op 1)
//  or checked (op 2) readout. rsp_* returns one result per in-range sample and one
//  result per channel on a readout, tlast on the final one.
//  Channel records live in one RAM with a registered read; an
//  item is read, modified and written back before the next is taken.
//  An averaged sample is read, loaded, divided in the shared divider and
//  written back; other samples skip the divide. A readout reads and emits
//  each channel in turn. The divider sets the rate.
//  The csr_* APB port holds the limits, the invalid marker and the two
//  intervals; write it only while the block is idle.
//  Reset clears all channel records at once through per-entry valid bits,
//  so no clearing pass is needed. When the receiver stalls the result
//  holds in the output register and the sequencer waits before writing
//  back or reading the next channel.
// ----------------------------------------------------------------------------
`default_nettype none
module sensor_sample_aggregator_core #(
   parameter int CHANNELS   = ssa_pkg::CHANNELS_DEF,
   parameter int COUNT_BITS = ssa_pkg::COUNT_BITS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // channel[1:0], now_time[33:2], display_value[65:34],
   // unclipped_value[97:66], base_value[129:98], zero fill
   input  wire logic [135:0] req_tdata,
   // op[1:0], is_consumption[2], update_flags[3]
   input  wire logic [3:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // out_channel[1:0], average_value[33:2], current_value[65:34],
   // previous_value[97:66], current_unclipped[129:98],
   // previous_unclipped[161:130], day_base[193:162], sent_unclipped[225:194],
   // set_send_time[257:226], send_pending[258], zero fill
   output logic [263:0]      rsp_tdata,
   // is_readout[0]
   output logic              rsp_tuser,
   output logic              rsp_tlast,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [4:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   localparam int AW   = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
   localparam int NRES = CHANNELS < ssa_pkg::MAX_RESULTS ? CHANNELS : ssa_pkg::MAX_RESULTS;
   localparam int SB   = ssa_pkg::SUM_BITS;
   localparam int NB   = ssa_pkg::DIVIDEND_BITS;

   localparam logic [1:0] OP_SAMPLE  = 2'd0;
   localparam logic [1:0] OP_RAW     = 2'd1;
   localparam logic [1:0] OP_CHECKED = 2'd2;

   localparam logic [2:0] REG_LOWER  = 3'd0;
   localparam logic [2:0] REG_UPPER  = 3'd1;
   localparam logic [2:0] REG_MARKER = 3'd2;
   localparam logic [2:0] REG_SEND   = 3'd3;
   localparam logic [2:0] REG_INVAL  = 3'd4;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_RD      = 3'd1;
   localparam logic [2:0] ST_LOAD    = 3'd2;
   localparam logic [2:0] ST_DIV     = 3'd3;
   localparam logic [2:0] ST_WR      = 3'd4;
   localparam logic [2:0] ST_RO_RD   = 3'd5;
   localparam logic [2:0] ST_RO_EMIT = 3'd6;

   typedef struct packed {
      logic [COUNT_BITS-1:0] count;
      logic signed [SB-1:0]  sum;
      logic signed [31:0]    avg;
      logic signed [31:0]    cur;
      logic signed [31:0]    prev;
      logic signed [31:0]    cu;
      logic signed [31:0]    pu;
      logic signed [31:0]    base;
      logic signed [31:0]    sentu;
      logic [31:0]           sendt;
   } rec_type;

   // configuration
   logic signed [31:0] lower_ff, upper_ff, marker_ff;
   logic [31:0]        sendiv_ff, inval_ff;
   logic               csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff  <= ssa_pkg::LOWER_RST;
         upper_ff  <= ssa_pkg::UPPER_RST;
         marker_ff <= ssa_pkg::MARKER_RST;
         sendiv_ff <= ssa_pkg::SEND_RST;
         inval_ff  <= ssa_pkg::INVAL_RST;
      end else if (csr_wr) begin
         case (csr_paddr[4:2])
            REG_LOWER:  lower_ff  <= csr_pwdata;
            REG_UPPER:  upper_ff  <= csr_pwdata;
            REG_MARKER: marker_ff <= csr_pwdata;
            REG_SEND:   sendiv_ff <= csr_pwdata;
            REG_INVAL:  inval_ff  <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         REG_LOWER:  csr_prdata = lower_ff;
         REG_UPPER:  csr_prdata = upper_ff;
         REG_MARKER: csr_prdata = marker_ff;
         REG_SEND:   csr_prdata = sendiv_ff;
         REG_INVAL:  csr_prdata = inval_ff;
         default:    csr_prdata = '0;
      endcase
   end

   // control and item registers
   logic [2:0]         state_ff, state_in;
   logic [1:0]         op_ff, op_in;
   logic [AW-1:0]      ch_ff, ch_in;
   logic [31:0]        now_ff, now_in;
   logic signed [31:0] disp_ff, disp_in, uncl_ff, uncl_in, base_ff, base_in;
   logic               cons_ff, cons_in;
   logic [AW-1:0]      ro_idx_ff, ro_idx_in;
   logic               first_ff, first_in, pending_ff, pending_in;
   logic [31:0]        last_send_ff, last_send_in, capt_ff, capt_in;
   logic [CHANNELS-1:0] valid_ff, valid_in, clr_ff, clr_in;
   rec_type            rec_ff, rec_in;
   logic               neg_ff, neg_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [263:0]       rsp_data_ff, rsp_data_in;
   logic               rsp_user_ff, rsp_user_in, rsp_last_ff, rsp_last_in;
   logic               out_free;

   // RAM and divider
   logic               ram_we, ram_re;
   logic [AW-1:0]      ram_raddr;
   logic [$bits(rec_type)-1:0] ram_rdata;
   rec_type            rec_rd;
   logic               div_start;
   logic [NB-1:0]      div_dividend, div_q;
   ssa_pkg::div_status_type div_st;

   // datapath helpers
   logic               req_acc, ch_ok;
   logic signed [32:0] d_ext, m_ext;
   logic               keep;
   logic signed [SB:0] sum_wide;
   logic signed [SB-1:0] sum_new;
   logic [NB-1:0]      mag;
   logic [COUNT_BITS-1:0] cnt_new;
   logic [31:0]        send_lim, stale_lim;
   logic signed [31:0] avg_res, a_out, v_out;
   logic               stale;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign ch_ok      = 32'(req_tdata[1:0]) < CHANNELS;

   always_comb begin
      rec_rd = rec_type'(ram_rdata);
      if (!valid_ff[ram_raddr]) begin
         rec_rd = '0;
      end else if (clr_ff[ram_raddr]) begin
         rec_rd.count = '0;
         rec_rd.sum   = '0;
      end
   end

   assign d_ext     = {disp_ff[31], disp_ff};
   assign m_ext     = {marker_ff[31], marker_ff};
   assign keep      = (d_ext > m_ext + ssa_pkg::TOL_Q) || (d_ext < m_ext - ssa_pkg::TOL_Q);
   assign sum_wide  = {rec_rd.sum[SB-1], rec_rd.sum} + (SB+1)'(disp_ff);
   assign send_lim  = now_ff > sendiv_ff ? now_ff - sendiv_ff : '0;
   assign stale_lim = now_ff > inval_ff ? now_ff - inval_ff : '0;
   assign cnt_new   = rec_rd.count + COUNT_BITS'(1);

   always_comb begin
      // saturate the sum at 48 bits
      if (sum_wide[SB] != sum_wide[SB-1]) begin
         sum_new = sum_wide[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
      end else begin
         sum_new = sum_wide[SB-1:0];
      end
      mag = sum_new[SB-1] ? NB'(-{sum_new[SB-1], sum_new}) : NB'(sum_new);
      div_dividend = mag + NB'(cnt_new >> 1);
   end

   always_comb begin
      // round-to-nearest quotient back to signed 32 bits, clamped
      if (neg_ff) begin
         if (div_q > NB'(64'h8000_0000)) begin
            avg_res = 32'sh8000_0000;
         end else begin
            avg_res = -$signed(div_q[31:0]);
         end
      end else if (div_q > NB'(64'h7FFF_FFFF)) begin
         avg_res = 32'sh7FFF_FFFF;
      end else begin
         avg_res = div_q[31:0];
      end
   end

   always_comb begin
      a_out = rec_rd.avg;
      v_out = rec_rd.cur;
      stale = stale_lim >= rec_rd.sendt;
      if (op_ff == OP_CHECKED) begin
         if (a_out < lower_ff || a_out > upper_ff) a_out = marker_ff;
         if (v_out < lower_ff || v_out > upper_ff) v_out = marker_ff;
         if (stale) begin
            a_out = marker_ff;
            v_out = marker_ff;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      ch_in        = ch_ff;
      now_in       = now_ff;
      disp_in      = disp_ff;
      uncl_in      = uncl_ff;
      base_in      = base_ff;
      cons_in      = cons_ff;
      ro_idx_in    = ro_idx_ff;
      first_in     = first_ff;
      pending_in   = pending_ff;
      last_send_in = last_send_ff;
      capt_in      = capt_ff;
      valid_in     = valid_ff;
      clr_in       = clr_ff;
      rec_in       = rec_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_raddr    = ch_ff;
      div_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               op_in   = req_tuser[1:0];
               cons_in = req_tuser[2];
               ch_in   = AW'(req_tdata[1:0]);
               now_in  = req_tdata[33:2];
               disp_in = req_tdata[65:34];
               uncl_in = req_tdata[97:66];
               base_in = req_tdata[129:98];
               case (req_tuser[1:0])
                  OP_SAMPLE: begin
                     if (ch_ok) state_in = ST_RD;
                  end
                  OP_RAW, OP_CHECKED: begin
                     if (req_tuser[3]) begin
                        pending_in   = 1'b0;
                        first_in     = 1'b0;
                        capt_in      = last_send_ff;
                        last_send_in = req_tdata[33:2];
                        clr_in       = '1;
                     end
                     ro_idx_in = '0;
                     state_in  = ST_RO_RD;
                  end
                  default: ;
               endcase
            end
         end
         ST_RD: begin
            ram_re   = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            rec_in   = rec_rd;
            state_in = ST_WR;
            if (keep) begin
               if (!cons_ff && !(&rec_rd.count)) begin
                  rec_in.sum   = sum_new;
                  rec_in.count = cnt_new;
                  neg_in       = sum_new[SB-1];
                  div_start    = 1'b1;
                  state_in     = ST_DIV;
               end
               if (cons_ff) rec_in.base = base_ff;
               rec_in.prev  = rec_rd.cur;
               rec_in.pu    = rec_rd.cu;
               rec_in.cu    = uncl_ff;
               rec_in.cur   = disp_ff;
               rec_in.sendt = now_ff;
               if (first_ff || last_send_ff <= send_lim) begin
                  pending_in   = 1'b1;
                  last_send_in = now_ff;
                  first_in     = 1'b0;
                  rec_in.sentu = uncl_ff;
               end
            end
         end
         ST_DIV: begin
            if (div_st.done) begin
               rec_in.avg = avg_res;
               state_in   = ST_WR;
            end
         end
         ST_WR: begin
            if (out_free) begin
               ram_we           = 1'b1;
               valid_in[ch_ff]  = 1'b1;
               clr_in[ch_ff]    = 1'b0;
               rsp_valid_in     = 1'b1;
               rsp_data_in      = {5'b0, pending_ff, capt_ff, rec_ff.sentu, rec_ff.base,
                                   rec_ff.pu, rec_ff.cu, rec_ff.prev, rec_ff.cur,
                                   rec_ff.avg, 2'(ch_ff)};
               rsp_user_in      = 1'b0;
               rsp_last_in      = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         ST_RO_RD: begin
            ram_re    = 1'b1;
            ram_raddr = ro_idx_ff;
            state_in  = ST_RO_EMIT;
         end
         ST_RO_EMIT: begin
            ram_raddr = ro_idx_ff;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'b0, pending_ff, capt_ff, rec_rd.sentu, rec_rd.base,
                               rec_rd.pu, rec_rd.cu, rec_rd.prev, v_out, a_out,
                               2'(ro_idx_ff)};
               rsp_user_in  = 1'b1;
               rsp_last_in  = (ro_idx_ff == AW'(NRES - 1));
               if (ro_idx_ff == AW'(NRES - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  ro_idx_in = ro_idx_ff + AW'(1);
                  state_in  = ST_RO_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         first_ff     <= 1'b1;
         pending_ff   <= 1'b0;
         last_send_ff <= '0;
         capt_ff      <= '0;
         valid_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         ro_idx_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         pending_ff   <= pending_in;
         last_send_ff <= last_send_in;
         capt_ff      <= capt_in;
         valid_ff     <= valid_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         ro_idx_ff    <= ro_idx_in;
      end
      op_ff       <= op_in;
      ch_ff       <= ch_in;
      now_ff      <= now_in;
      disp_ff     <= disp_in;
      uncl_ff     <= uncl_in;
      base_ff     <= base_in;
      cons_ff     <= cons_in;
      rec_ff      <= rec_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   ssa_ram #(
      .WIDTH ($bits(rec_type)),
      .DEPTH (CHANNELS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ch_ff),
      .wdata (rec_ff),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   ssa_div #(
      .DIVISOR_W (COUNT_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (cnt_new),
      .quotient (div_q),
      .status   (div_st)
   );

   a_we_only_in_wr: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_WR) && out_free)
      else $error("record written outside write-back");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_st.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside divide wait");

   a_idle_div_quiet: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_st.busy)
      else $error("divider busy while accepting");

   a_upd_clears_pending: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_tuser[3] && (req_tuser[1:0] == OP_RAW || req_tuser[1:0] == OP_CHECKED))
      |=> !pending_ff && !first_ff)
      else $error("flag-clearing readout left pending set");
endmodule
`default_nettype wire

### rtl/ssa_ram.sv
// ----------------------------------------------------------------------------
// ssa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module ssa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4
) (
   input  wire logic                                  clock,
   input  wire logic                                  we,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                      wdata,
   input  wire logic                                  re,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                      rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

### rtl/ssa_div.sv
// ----------------------------------------------------------------------------
// ssa_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ssa_div #(
   parameter int DIVISOR_W = ssa_pkg::COUNT_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [ssa_pkg::DIVIDEND_BITS-1:0]   dividend,
   input  wire logic [DIVISOR_W-1:0]                divisor,
   output logic      [ssa_pkg::DIVIDEND_BITS-1:0]   quotient,
   output ssa_pkg::div_status_type                  status
);
   localparam int NW = ssa_pkg::DIVIDEND_BITS;
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0]        quo_ff, quo_in;
   logic [DIVISOR_W:0]   rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dsr_ff, dsr_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [DIVISOR_W:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DIVISOR_W-1:0], quo_ff[NW-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract where it fits
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;
endmodule
`default_nettype wire

### sim/sensor_sample_aggregator_core_tb.sv
// ----------------------------------------------------------------------------
// sensor_sample_aggregator_core_tb
// Drives samples and readouts into the aggregator with random gaps and
// stalls, predicts every channel result and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

typedef struct packed {
   logic [1:0]  chan;
   logic [31:0] avg;
   logic [31:0] cur;
   logic [31:0] prev;
   logic [31:0] cur_uncl;
   logic [31:0] prev_uncl;
   logic [31:0] base;
   logic [31:0] sent_uncl;
   logic [31:0] send_time;
   logic        pending;
   logic        readout;
   logic        last;
} chan_result_type;

class aggregator_scoreboard;
   localparam int NCH = 4;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;
   localparam longint SUM_MAX = (64'sd1 <<< 47) - 1;
   localparam longint SUM_MIN = -(64'sd1 <<< 47);
   localparam int TOL = 7209;

   logic signed [31:0] lower_limit, upper_limit, marker;
   logic [31:0] send_ivl, inval_ivl;
   logic [15:0] cnt [NCH];
   longint sum [NCH];
   logic signed [31:0] avg_v [NCH], val [NCH], prev_val [NCH], uncl [NCH];
   logic signed [31:0] prev_uncl [NCH], base_v [NCH], sent_uncl [NCH];
   logic [31:0] ch_time [NCH];
   bit first_pend, pend;
   logic [31:0] last_send, captured;
   chan_result_type expected_results [$];
   int errors;
   int checked;

   function new();
      lower_limit = 32'sh8000_0000; upper_limit = 32'sh7FFF_FFFF;
      marker = 65530675; send_ivl = 600; inval_ivl = 1800;
      for (int i = 0; i < NCH; i++) begin
         cnt[i] = 0; sum[i] = 0; avg_v[i] = 0; val[i] = 0; prev_val[i] = 0;
         uncl[i] = 0; prev_uncl[i] = 0; base_v[i] = 0; sent_uncl[i] = 0;
         ch_time[i] = 0;
      end
      first_pend = 1; pend = 0; last_send = 0; captured = 0;
      errors = 0; checked = 0;
   endfunction

   function void set_reg(int idx, logic [31:0] v);
      case (idx)
         0: lower_limit = v;
         1: upper_limit = v;
         2: marker = v;
         3: send_ivl = v;
         4: inval_ivl = v;
         default: ;
      endcase
   endfunction

   static function logic [31:0] sat_sub(logic [31:0] a, logic [31:0] b);
      return (a > b) ? a - b : 32'd0;
   endfunction

   function logic signed [31:0] rounded_mean(longint s, longint c);
      longint mag, q;
      mag = (s < 0) ? -s : s;
      q = (mag + c / 2) / c;
      if (s < 0) q = -q;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q[31:0];
   endfunction

   function void push(int ch, logic [31:0] a, logic [31:0] v, bit ro, bit lst);
      chan_result_type r;
      r.chan = 2'(ch); r.avg = a; r.cur = v; r.prev = prev_val[ch];
      r.cur_uncl = uncl[ch]; r.prev_uncl = prev_uncl[ch]; r.base = base_v[ch];
      r.sent_uncl = sent_uncl[ch]; r.send_time = captured; r.pending = pend;
      r.readout = ro; r.last = lst;
      expected_results.push_back(r);
   endfunction

   function void note_item(logic [1:0] op, logic [1:0] ch, logic [31:0] now,
                           logic signed [31:0] disp, logic signed [31:0] ucv,
                           logic signed [31:0] bsv, bit cons, bit upd);
      longint d, m, s;
      logic signed [31:0] a, v;
      if (op == 2'd0) begin
         d = disp; m = marker;
         if (d > m + TOL || d < m - TOL) begin
            if (!cons && cnt[ch] < COUNT_MAX) begin
               s = sum[ch] + d;
               if (s > SUM_MAX) s = SUM_MAX;
               if (s < SUM_MIN) s = SUM_MIN;
               sum[ch] = s;
               cnt[ch]++;
               avg_v[ch] = rounded_mean(s, cnt[ch]);
            end
            if (cons) base_v[ch] = bsv;
            prev_val[ch] = val[ch];
            prev_uncl[ch] = uncl[ch];
            uncl[ch] = ucv;
            val[ch] = disp;
            ch_time[ch] = now;
            if (first_pend) begin
               pend = 1; last_send = now; first_pend = 0; sent_uncl[ch] = ucv;
            end else if (last_send <= sat_sub(now, send_ivl)) begin
               last_send = now; sent_uncl[ch] = ucv; pend = 1;
            end
         end
         push(ch, avg_v[ch], val[ch], 0, 1);
      end else if (op != 2'd3) begin
         if (upd) begin
            pend = 0; first_pend = 0; captured = last_send; last_send = now;
            for (int i = 0; i < NCH; i++) begin
               cnt[i] = 0; sum[i] = 0;
            end
         end
         for (int i = 0; i < NCH; i++) begin
            a = avg_v[i]; v = val[i];
            if (op == 2'd2) begin
               if (a < lower_limit || a > upper_limit) a = marker;
               if (v < lower_limit || v > upper_limit) v = marker;
               if (sat_sub(now, inval_ivl) >= ch_time[i]) begin
                  a = marker; v = marker;
               end
            end
            push(i, a, v, 1, i == NCH - 1);
         end
      end
   endfunction

   function void check_result(chan_result_type got);
      chan_result_type e;
      checked++;
      if (expected_results.size() == 0) begin
         $error("unexpected result on channel %0d", got.chan);
         errors++;
         return;
      end
      e = expected_results.pop_front();
      if (got.chan !== e.chan) begin
         $error("out_channel exp %0d got %0d", e.chan, got.chan); errors++;
      end
      if (got.avg !== e.avg) begin
         $error("average_value exp %h got %h", e.avg, got.avg); errors++;
      end
      if (got.cur !== e.cur) begin
         $error("current_value exp %h got %h", e.cur, got.cur); errors++;
      end
      if (got.prev !== e.prev) begin
         $error("previous_value exp %h got %h", e.prev, got.prev); errors++;
      end
      if (got.cur_uncl !== e.cur_uncl) begin
         $error("current_unclipped exp %h got %h", e.cur_uncl, got.cur_uncl);
         errors++;
      end
      if (got.prev_uncl !== e.prev_uncl) begin
         $error("previous_unclipped exp %h got %h", e.prev_uncl, got.prev_uncl);
         errors++;
      end
      if (got.base !== e.base) begin
         $error("day_base exp %h got %h", e.base, got.base); errors++;
      end
      if (got.sent_uncl !== e.sent_uncl) begin
         $error("sent_unclipped exp %h got %h", e.sent_uncl, got.sent_uncl);
         errors++;
      end
      if (got.send_time !== e.send_time) begin
         $error("set_send_time exp %h got %h", e.send_time, got.send_time);
         errors++;
      end
      if (got.pending !== e.pending) begin
         $error("send_pending exp %b got %b", e.pending, got.pending); errors++;
      end
      if (got.readout !== e.readout) begin
         $error("is_readout exp %b got %b", e.readout, got.readout); errors++;
      end
      if (got.last !== e.last) begin
         $error("last exp %b got %b", e.last, got.last); errors++;
      end
   endfunction
endclass

module sensor_sample_aggregator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_SAMPLE  = 2'd0;
   localparam logic [1:0] OP_RAW     = 2'd1;
   localparam logic [1:0] OP_CHECKED = 2'd2;
   localparam logic [1:0] OP_UNUSED  = 2'd3;
   localparam int REG_LOWER  = 0;
   localparam int REG_UPPER  = 1;
   localparam int REG_MARKER = 2;
   localparam int REG_SEND   = 3;
   localparam int REG_INVAL  = 4;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   wire  req_tready;
   logic [135:0] req_tdata = '0;
   logic [3:0] req_tuser = '0;
   wire  rsp_tvalid;
   logic rsp_tready = 0;
   wire  [263:0] rsp_tdata;
   wire  rsp_tuser, rsp_tlast;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [4:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   wire  [31:0] csr_prdata;
   wire  csr_pready;

   aggregator_scoreboard sb;
   int cycles = 0;
   bit no_idle = 0;
   int samples_sent = 0, readouts_sent = 0;
   logic [31:0] clock_s = 0;
   logic signed [31:0] cur_marker = 65530675;

   sensor_sample_aggregator_core DUT (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver: random stalls, none during the quiet stretch
   always @(posedge clock) begin
      if (reset) rsp_tready <= 0;
      else rsp_tready <= no_idle || ($urandom_range(99) >= 27);
   end

   always @(posedge clock) begin
      chan_result_type r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         r.chan = rsp_tdata[1:0];       r.avg = rsp_tdata[33:2];
         r.cur = rsp_tdata[65:34];      r.prev = rsp_tdata[97:66];
         r.cur_uncl = rsp_tdata[129:98]; r.prev_uncl = rsp_tdata[161:130];
         r.base = rsp_tdata[193:162];   r.sent_uncl = rsp_tdata[225:194];
         r.send_time = rsp_tdata[257:226]; r.pending = rsp_tdata[258];
         r.readout = rsp_tuser;         r.last = rsp_tlast;
         sb.check_result(r);
      end
   end

   task automatic csr_write(int idx, logic [31:0] v);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= 5'(idx * 4); csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      sb.set_reg(idx, v);
      if (idx == REG_MARKER) cur_marker = v;
      @(posedge clock);
   endtask

   // valid stays high after a transfer until the next item or a drain
   task automatic send_item(logic [1:0] op, logic [1:0] ch, logic [31:0] now,
                            logic [31:0] disp, logic [31:0] ucv, logic [31:0] bsv,
                            bit cons, bit upd);
      while (!no_idle && $urandom_range(99) < 27) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {6'd0, bsv, ucv, disp, now, ch};
      req_tuser <= {upd, cons, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_item(op, ch, now, disp, ucv, bsv, cons, upd);
      if (op == OP_SAMPLE) samples_sent++;
      else if (op != OP_UNUSED) readouts_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(5))
         0: return 32'h8000_0000 | $urandom_range(3);
         1: return 32'h7FFF_FFFF - $urandom_range(3);
         2: return cur_marker + $urandom_range(14418) - 7209;
         3: return cur_marker + (($urandom_range(1)) ? 7210 : -7210);
         4: return $urandom_range(65536 * 200) - 65536 * 100;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_item();
      logic [31:0] now;
      int k;
      k = $urandom_range(99);
      case ($urandom_range(9))
         0: now = $urandom;
         1: now = clock_s - $urandom_range(50);
         default: begin
            clock_s = clock_s + $urandom_range(900);
            now = clock_s;
         end
      endcase
      if (k < 70)
         send_item(OP_SAMPLE, 2'($urandom_range(3)), now, rand_value(), $urandom,
                   $urandom, $urandom_range(3) == 0, 1'($urandom_range(1)));
      else if (k < 96)
         send_item(($urandom_range(1)) ? OP_CHECKED : OP_RAW, 2'($urandom_range(3)),
                   now, $urandom, $urandom, $urandom, 1'($urandom_range(1)),
                   1'($urandom_range(1)));
      else
         send_item(OP_UNUSED, 2'($urandom_range(3)), now, $urandom, $urandom,
                   $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   initial begin
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: first sample, marker band edges, consumption, both readouts
      send_item(OP_CHECKED, 0, 0, 0, 0, 0, 0, 0);
      send_item(OP_SAMPLE, 0, 100, 32'h0001_0000, 32'h0002_0000, 5, 0, 0);
      send_item(OP_SAMPLE, 1, 110, 65530675 + 7209, 1, 2, 0, 0);
      send_item(OP_SAMPLE, 1, 110, 65530675 - 7209, 1, 2, 0, 0);
      send_item(OP_SAMPLE, 1, 120, 65530675 + 7210, 3, 4, 0, 0);
      send_item(OP_SAMPLE, 2, 130, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1, 0);
      send_item(OP_SAMPLE, 3, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                32'h8000_0000, 0, 1);
      send_item(OP_SAMPLE, 3, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 7, 8, 0, 0);
      send_item(OP_SAMPLE, 0, 101, 32'hFFFF_0001, 9, 9, 0, 0);
      send_item(OP_SAMPLE, 0, 800, 32'h0000_0003, 9, 9, 0, 0);
      send_item(OP_RAW, 0, 900, 0, 0, 0, 0, 0);
      send_item(OP_CHECKED, 3, 2000, 0, 0, 0, 0, 1);
      send_item(OP_UNUSED, 1, 5, 0, 0, 0, 1, 1);
      send_item(OP_SAMPLE, 2, 2100, 32'hFFFF_FFFF, 1, 1, 0, 0);
      send_item(OP_CHECKED, 0, 32'hFFFF_FFFF, 0, 0, 0, 1, 0);
      send_item(OP_RAW, 0, 3000, 0, 0, 0, 0, 1);
      drain();

      // settings: tight limits and zero intervals, then wide extremes
      csr_write(REG_LOWER, 32'hFFFF_0000);
      csr_write(REG_UPPER, 32'h0001_0000);
      csr_write(REG_MARKER, 32'h8000_0000);
      csr_write(REG_SEND, 0);
      csr_write(REG_INVAL, 0);
      for (int i = 0; i < 50; i++) random_item();
      drain();

      csr_write(REG_LOWER, 32'h7FFF_FFFF);
      csr_write(REG_UPPER, 32'h8000_0000);
      csr_write(REG_MARKER, 32'h7FFF_FFFF);
      csr_write(REG_SEND, 32'hFFFF_FFFF);
      csr_write(REG_INVAL, 32'hFFFF_FFFF);
      no_idle = 1;
      for (int i = 0; i < 40; i++) random_item();
      drain();
      no_idle = 0;

      csr_write(REG_LOWER, 32'hFF9C_0000);
      csr_write(REG_UPPER, 32'h0064_0000);
      csr_write(REG_MARKER, 32'd65530675);
      csr_write(REG_SEND, 300);
      csr_write(REG_INVAL, 1200);
      for (int i = 0; i < 80; i++) random_item();
      drain();

      $display("covered %0d samples and %0d readouts, %0d results checked",
               samples_sent, readouts_sent, sb.checked);
      $display("four register settings including limit and interval extremes");
      if (sb.errors == 0 && sb.expected_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire
